@@ src/eeb_pkg.sv @@
package eeb_pkg;

  // Register map
  localparam int unsigned RegCount     = 4;
  localparam int unsigned RegIdxWidth  = $clog2(RegCount);
  localparam int unsigned PaddrWidth   = RegIdxWidth + 2;
  localparam int unsigned PdataWidth   = 32;

  typedef enum logic [RegIdxWidth-1:0] {
    REG_CONTROL_BYTE    = 2'd0,
    REG_ACK_LIMIT_LONG  = 2'd1,
    REG_ACK_LIMIT_SHORT = 2'd2,
    REG_WRITE_WAIT      = 2'd3
  } eeb_reg_e;

  // Field widths
  localparam int unsigned ByteWidth  = 8;
  localparam int unsigned AddrWidth  = 16;
  localparam int unsigned LimitWidth = 11;
  localparam int unsigned WaitWidth  = 16;
  localparam int unsigned BitIdxWidth = 4;

  // Register reset values
  localparam logic [ByteWidth-1:0]  ControlByteReset = 8'hA8;
  localparam logic [LimitWidth-1:0] AckLongReset     = 11'd1100;
  localparam logic [LimitWidth-1:0] AckShortReset    = 11'd650;
  localparam logic [WaitWidth-1:0]  WriteWaitReset   = 16'd13000;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_READ  = 2'd2,
    ACT_RSVD  = 2'd3
  } eeb_action_e;

  typedef enum logic [21:0] {
    PH_IDLE     = 22'h000001,
    PH_START_HI = 22'h000002,
    PH_START_LO = 22'h000004,
    PH_SEND_CTL = 22'h000008,
    PH_ACK_CTL  = 22'h000010,
    PH_SEND_AH  = 22'h000020,
    PH_ACK_AH   = 22'h000040,
    PH_SEND_AL  = 22'h000080,
    PH_ACK_AL   = 22'h000100,
    PH_SEND_DAT = 22'h000200,
    PH_ACK_DAT  = 22'h000400,
    PH_STOP_LO  = 22'h000800,
    PH_STOP_HI  = 22'h001000,
    PH_STOP_REL = 22'h002000,
    PH_WAIT     = 22'h004000,
    PH_RS_PREP  = 22'h008000,
    PH_RS_HI    = 22'h010000,
    PH_RS_START = 22'h020000,
    PH_RS_LO    = 22'h040000,
    PH_SEND_CRD = 22'h080000,
    PH_ACK_CRD  = 22'h100000,
    PH_READ     = 22'h200000
  } eeb_phase_e;

  typedef struct packed {
    logic [1:0]           action;
    logic [AddrWidth-1:0] address;
    logic [ByteWidth-1:0] write_data;
    logic                 sda_in;
  } eeb_req_t;

  typedef struct packed {
    logic                 scl_level;
    logic                 sda_level;
    logic                 busy_res;
    logic                 done_res;
    logic [ByteWidth-1:0] read_byte;
    logic                 ack_missing;
  } eeb_res_t;

  typedef struct packed {
    logic [ByteWidth-1:0]  control_byte;
    logic [LimitWidth-1:0] ack_limit_long;
    logic [LimitWidth-1:0] ack_limit_short;
    logic [WaitWidth-1:0]  write_wait_ticks;
  } eeb_cfg_t;

endpackage

@@ src/eeb_stream_if.sv @@
interface eeb_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

@@ src/eeb_cfg_regs.sv @@
module eeb_cfg_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [eeb_pkg::PaddrWidth-1:0]  paddr,
  input  logic [eeb_pkg::PdataWidth-1:0]  pwdata,
  output logic [eeb_pkg::PdataWidth-1:0]  prdata,
  output logic                            pready,
  output eeb_pkg::eeb_cfg_t               cfg_o
);
  import eeb_pkg::*;

  eeb_cfg_t cfg_q;
  logic     wr_en;
  eeb_reg_e reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = eeb_reg_e'(paddr[PaddrWidth-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.control_byte     <= ControlByteReset;
      cfg_q.ack_limit_long   <= AckLongReset;
      cfg_q.ack_limit_short  <= AckShortReset;
      cfg_q.write_wait_ticks <= WriteWaitReset;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_CONTROL_BYTE:    cfg_q.control_byte     <= pwdata[ByteWidth-1:0];
        REG_ACK_LIMIT_LONG:  cfg_q.ack_limit_long   <= pwdata[LimitWidth-1:0];
        REG_ACK_LIMIT_SHORT: cfg_q.ack_limit_short  <= pwdata[LimitWidth-1:0];
        REG_WRITE_WAIT:      cfg_q.write_wait_ticks <= pwdata[WaitWidth-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_CONTROL_BYTE:    prdata[ByteWidth-1:0]  = cfg_q.control_byte;
      REG_ACK_LIMIT_LONG:  prdata[LimitWidth-1:0] = cfg_q.ack_limit_long;
      REG_ACK_LIMIT_SHORT: prdata[LimitWidth-1:0] = cfg_q.ack_limit_short;
      REG_WRITE_WAIT:      prdata[WaitWidth-1:0]  = cfg_q.write_wait_ticks;
      default: ;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

@@ src/eeb_engine.sv @@
module eeb_engine (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  eeb_pkg::eeb_req_t req_i,
  input  eeb_pkg::eeb_cfg_t cfg_i,
  output eeb_pkg::eeb_res_t res_o
);
  import eeb_pkg::*;

  eeb_phase_e             phase_q, phase_d;
  logic [BitIdxWidth-1:0] bit_idx_q, bit_idx_d;
  logic [ByteWidth-1:0]   shift_q, shift_d;
  logic [LimitWidth-1:0]  poll_q, poll_d;
  logic [WaitWidth-1:0]   wait_q, wait_d;
  logic [AddrWidth-1:0]   addr_q, addr_d;
  logic [ByteWidth-1:0]   data_q, data_d;
  logic                   is_read_q, is_read_d;
  logic [ByteWidth-1:0]   last_rd_q, last_rd_d;
  logic                   ack_flag_q, ack_flag_d;

  logic                   scl, sda, done;
  logic [LimitWidth-1:0]  poll_inc, limit;
  logic [WaitWidth-1:0]   wait_inc;
  logic [ByteWidth-1:0]   shift_in;
  logic                   ack_end;
  logic                   last_bit;

  assign poll_inc = poll_q + 1'b1;
  assign wait_inc = wait_q + 1'b1;
  assign shift_in = {shift_q[ByteWidth-2:0], req_i.sda_in};
  assign last_bit = &bit_idx_q;
  // reads poll with the short limit except in the read-control ack, everything else long
  assign limit    = (is_read_q && phase_q != PH_ACK_CRD) ? cfg_i.ack_limit_short
                                                         : cfg_i.ack_limit_long;
  assign ack_end  = !req_i.sda_in || (poll_inc >= limit);

  always_comb begin
    phase_d    = phase_q;
    bit_idx_d  = bit_idx_q;
    shift_d    = shift_q;
    poll_d     = poll_q;
    wait_d     = wait_q;
    addr_d     = addr_q;
    data_d     = data_q;
    is_read_d  = is_read_q;
    last_rd_d  = last_rd_q;
    ack_flag_d = ack_flag_q;
    scl        = 1'b1;
    sda        = 1'b1;
    done       = 1'b0;

    unique case (phase_q)
      PH_IDLE: begin
        if (req_i.action == ACT_WRITE || req_i.action == ACT_READ) begin
          addr_d    = req_i.address;
          data_d    = req_i.write_data;
          is_read_d = (req_i.action == ACT_READ);
          bit_idx_d = '0;
          poll_d    = '0;
          wait_d    = '0;
          phase_d   = PH_START_HI;
        end
      end
      PH_START_HI: begin
        sda     = 1'b0;
        phase_d = PH_START_LO;
      end
      PH_START_LO: begin
        scl       = 1'b0;
        sda       = 1'b0;
        phase_d   = PH_SEND_CTL;
        shift_d   = cfg_i.control_byte;
        bit_idx_d = '0;
      end
      PH_SEND_CTL, PH_SEND_AH, PH_SEND_AL, PH_SEND_DAT, PH_SEND_CRD: begin
        sda = shift_q[3'd7 - bit_idx_q[3:1]];
        scl = bit_idx_q[0];
        if (last_bit) begin
          poll_d = '0;
          unique case (phase_q)
            PH_SEND_CTL: phase_d = PH_ACK_CTL;
            PH_SEND_AH:  phase_d = PH_ACK_AH;
            PH_SEND_AL:  phase_d = PH_ACK_AL;
            PH_SEND_DAT: phase_d = PH_ACK_DAT;
            default:     phase_d = PH_ACK_CRD;
          endcase
        end else begin
          bit_idx_d = bit_idx_q + 1'b1;
        end
      end
      PH_ACK_CTL, PH_ACK_AH, PH_ACK_AL, PH_ACK_DAT, PH_ACK_CRD: begin
        if (req_i.sda_in) begin
          poll_d = poll_inc;
        end
        if (ack_end) begin
          ack_flag_d = req_i.sda_in;
          unique case (phase_q)
            PH_ACK_CTL: begin
              phase_d   = PH_SEND_AH;
              shift_d   = addr_q[AddrWidth-1:ByteWidth];
              bit_idx_d = '0;
            end
            PH_ACK_AH: begin
              phase_d   = PH_SEND_AL;
              shift_d   = addr_q[ByteWidth-1:0];
              bit_idx_d = '0;
            end
            PH_ACK_AL: begin
              if (is_read_q) begin
                phase_d = PH_RS_PREP;
              end else begin
                phase_d   = PH_SEND_DAT;
                shift_d   = data_q;
                bit_idx_d = '0;
              end
            end
            PH_ACK_CRD: begin
              phase_d   = PH_READ;
              shift_d   = '0;
              bit_idx_d = '0;
            end
            default: phase_d = PH_STOP_LO;
          endcase
        end
      end
      PH_RS_PREP: begin
        scl     = 1'b0;
        phase_d = PH_RS_HI;
      end
      PH_RS_HI: phase_d = PH_RS_START;
      PH_RS_START: begin
        sda     = 1'b0;
        phase_d = PH_RS_LO;
      end
      PH_RS_LO: begin
        scl       = 1'b0;
        sda       = 1'b0;
        phase_d   = PH_SEND_CRD;
        shift_d   = cfg_i.control_byte + 1'b1;
        bit_idx_d = '0;
      end
      PH_READ: begin
        scl = bit_idx_q[0];
        // sample on the SCL-high half of each bit
        if (bit_idx_q[0]) begin
          shift_d = shift_in;
        end
        if (last_bit) begin
          last_rd_d = shift_in;
          phase_d   = PH_STOP_LO;
        end else begin
          bit_idx_d = bit_idx_q + 1'b1;
        end
      end
      PH_STOP_LO: begin
        scl     = 1'b0;
        sda     = 1'b0;
        phase_d = PH_STOP_HI;
      end
      PH_STOP_HI: begin
        sda     = 1'b0;
        phase_d = PH_STOP_REL;
      end
      PH_STOP_REL: begin
        if (!is_read_q && cfg_i.write_wait_ticks != '0) begin
          phase_d = PH_WAIT;
          wait_d  = '0;
        end else begin
          phase_d = PH_IDLE;
          done    = 1'b1;
        end
      end
      PH_WAIT: begin
        wait_d = wait_inc;
        if (wait_inc >= cfg_i.write_wait_ticks) begin
          phase_d = PH_IDLE;
          done    = 1'b1;
        end
      end
      default: phase_d = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      bit_idx_q  <= '0;
      shift_q    <= '0;
      poll_q     <= '0;
      wait_q     <= '0;
      addr_q     <= '0;
      data_q     <= '0;
      is_read_q  <= 1'b0;
      last_rd_q  <= '0;
      ack_flag_q <= 1'b0;
    end else if (accept_i) begin
      phase_q    <= phase_d;
      bit_idx_q  <= bit_idx_d;
      shift_q    <= shift_d;
      poll_q     <= poll_d;
      wait_q     <= wait_d;
      addr_q     <= addr_d;
      data_q     <= data_d;
      is_read_q  <= is_read_d;
      last_rd_q  <= last_rd_d;
      ack_flag_q <= ack_flag_d;
    end
  end

  assign res_o.scl_level   = scl;
  assign res_o.sda_level   = sda;
  assign res_o.busy_res    = (phase_d != PH_IDLE);
  assign res_o.done_res    = done;
  assign res_o.read_byte   = last_rd_d;
  assign res_o.ack_missing = ack_flag_d;

`ifndef ASSERT_OFF
  a_done_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && done |=> phase_q == PH_IDLE)
    else $error("done without return to idle");

  a_busy_tracks_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i |=> (phase_q != PH_IDLE) == $past(res_o.busy_res))
    else $error("busy flag disagrees with phase");

  a_read_capture: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && phase_q == PH_READ && last_bit |=> last_rd_q == shift_q)
    else $error("read byte not captured from shifter");

  a_tick_stays_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && phase_q == PH_IDLE && req_i.action != ACT_WRITE
      && req_i.action != ACT_READ |=> phase_q == PH_IDLE)
    else $error("left idle without a command");
`endif

endmodule

@@ src/eeb_out_reg.sv @@
module eeb_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  eeb_pkg::eeb_res_t res_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output eeb_pkg::eeb_res_t res_o
);
  import eeb_pkg::*;

  logic     valid_q;
  eeb_res_t res_q;
  logic     load;

  // free slot, or the held result leaves this cycle
  assign in_ready_o = !valid_q || out_ready_i;
  assign load       = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

@@ src/i2c_eeprom_byte_master_top.sv @@
// Channel   Dir  Payload                                        Handshake
// req_i     in   action, address, write_data, sda_in            valid/ready
// res_o     out  scl_level, sda_level, busy_res, done_res,      valid/ready
//                read_byte, ack_missing
// apb       in   psel/penable/pwrite/paddr/pwdata -> prdata     pready tied high
//
// One request per cycle unless a stall on res_o holds the output register full;
// each request is one half-bit bus phase and yields one result, registered in the output register.
// The phase step is a single pass of logic from state plus request into the
// state and result registers; the output register frees as its result leaves.
// A stall on res_o holds req_i.ready low only while the output register is full.
// Reset (rst_ni, async, active low) puts the bus engine in idle and loads the
// register reset values; no clearing pass is needed.
module i2c_eeprom_byte_master_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  eeb_stream_if.sink                     req_i,
  eeb_stream_if.source                   res_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [eeb_pkg::PaddrWidth-1:0] paddr,
  input  logic [eeb_pkg::PdataWidth-1:0] pwdata,
  output logic [eeb_pkg::PdataWidth-1:0] prdata,
  output logic                           pready
);
  import eeb_pkg::*;

  eeb_cfg_t cfg;
  eeb_res_t step_res;
  eeb_res_t held_res;
  logic     in_ready;
  logic     accept;

  // request taken when the output register can take its result
  assign accept      = req_i.valid && in_ready;
  assign req_i.ready = in_ready;

  // APB register file: control byte, ack limits, write wait
  eeb_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // bus phase sequencer; state advances only on an accepted request
  eeb_engine u_engine (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .req_i    (req_i.payload),
    .cfg_i    (cfg),
    .res_o    (step_res)
  );

  // result register decoupling the two handshakes
  eeb_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .res_i       (step_res),
    .in_ready_o  (in_ready),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .res_o       (held_res)
  );

  assign res_o.payload = held_res;

endmodule
